@@ rtl/jsu_pkg.sv @@
// Types, constants and decode functions shared by the JSON string unescape block.
package jsu_pkg;

   localparam logic [31:0] COUNT_LIMIT = 32'd1048575;
   localparam int unsigned COUNT_W = 20;
   localparam int unsigned CP_W    = 21;
   localparam logic [CP_W-1:0] UNICODE_LAST = 21'h10FFFF;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_U  = 8'h75;

   localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
   localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
   localparam logic [15:0] LOW_SURR_HI  = 16'hDFFF;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_DATA  = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_CHAR  = 2'd0,
      ST_CLOSE = 2'd1,
      ST_ERROR = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      MODE_IDLE        = 4'd0,
      MODE_BODY        = 4'd1,
      MODE_CONT        = 4'd2,
      MODE_ESC         = 4'd3,
      MODE_HEX         = 4'd4,
      MODE_AFTER_HIGH  = 4'd5,
      MODE_AFTER_SLASH = 4'd6
   } mode_type;

   typedef struct packed {
      logic            emit;
      status_type      status;
      logic [CP_W-1:0] cp;
      mode_type        mode;
      logic [CP_W-1:0] acc;
      logic [1:0]      cont;
   } act_type;

   typedef struct packed {
      logic               emit;
      status_type         status;
      logic [CP_W-1:0]    cp;
   } emit_type;

   typedef struct packed {
      status_type         status;
      logic [CP_W-1:0]    code_point;
      logic [COUNT_W-1:0] char_count;
      logic [CP_W-1:0]    max_code_point;
      logic               last;
   } rsp_entry_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] nibble;
   } hex_type;

   function automatic act_type body_act(input logic [7:0] b, input logic [CP_W-1:0] largest);
      act_type a;
      a        = '0;
      a.status = ST_CHAR;
      a.mode   = MODE_BODY;
      if (b == CH_BSLASH) begin
         a.mode = MODE_ESC;
      end else if (b == CH_QUOTE) begin
         a.emit   = 1'b1;
         a.status = (largest > UNICODE_LAST) ? ST_ERROR : ST_CLOSE;
         a.mode   = MODE_IDLE;
      end else if (!b[7]) begin
         a.emit = 1'b1;
         a.cp   = CP_W'(b);
      end else if (b[7:5] == 3'b110) begin
         a.acc  = CP_W'({b[4:0], 6'b0});
         a.cont = 2'd1;
         a.mode = MODE_CONT;
      end else if (b[7:4] == 4'b1110) begin
         a.acc  = CP_W'({b[3:0], 12'b0});
         a.cont = 2'd2;
         a.mode = MODE_CONT;
      end else if (b[7:3] == 5'b11110) begin
         a.acc  = CP_W'({b[2:0], 18'b0});
         a.cont = 2'd3;
         a.mode = MODE_CONT;
      end else begin
         a.emit   = 1'b1;
         a.status = ST_ERROR;
         a.mode   = MODE_IDLE;
      end
      return a;
   endfunction

   function automatic act_type esc_act(input logic [7:0] b);
      act_type a;
      a        = '0;
      a.status = ST_CHAR;
      a.emit   = 1'b1;
      a.mode   = MODE_BODY;
      case (b)
         CH_QUOTE:  a.cp = CP_W'(8'h22);
         CH_BSLASH: a.cp = CP_W'(8'h5C);
         CH_LOW_B:  a.cp = CP_W'(8'h08);
         CH_LOW_F:  a.cp = CP_W'(8'h0C);
         CH_LOW_N:  a.cp = CP_W'(8'h0A);
         CH_LOW_R:  a.cp = CP_W'(8'h0D);
         CH_LOW_T:  a.cp = CP_W'(8'h09);
         CH_LOW_U: begin
            a.emit = 1'b0;
            a.mode = MODE_HEX;
         end
         default: begin
            a.status = ST_ERROR;
            a.mode   = MODE_IDLE;
         end
      endcase
      return a;
   endfunction

   function automatic hex_type hex_digit(input logic [7:0] b);
      hex_type h;
      h = '0;
      if (b >= 8'h30 && b <= 8'h39) begin
         h.valid  = 1'b1;
         h.nibble = 4'(b - 8'h30);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         h.valid  = 1'b1;
         h.nibble = 4'(b - 8'h37);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         h.valid  = 1'b1;
         h.nibble = 4'(b - 8'h57);
      end
      return h;
   endfunction

endpackage

@@ rtl/jsu_if.sv @@
// Request and response channel interfaces of the JSON string unescape block.
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface jsu_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [20:0] code_point;
   logic [19:0] char_count;
   logic [20:0] max_code_point;
   logic        last;

   modport source (output valid, output status, output code_point, output char_count,
                   output max_code_point, output last, input ready);
   modport sink (input valid, input status, input code_point, input char_count,
                 input max_code_point, input last, output ready);
endinterface

@@ rtl/json_string_unescape_utf8.sv @@
// Top level: JSON string body unescape with UTF-8 decode, one byte per request.
//
// req_ch carries one request per byte: kind start, data byte or end of buffer.
// rsp_ch returns decoded characters, the closing-quote report (count and largest
// code point) or an error; last marks the final response of one request.
// A request is decoded in the cycle it is accepted and its responses enter a
// three-entry response queue; its head register drives rsp_ch. Sustained rate
// is one request per cycle while rsp_ch.ready stays high and the queue is not
// filled by a request that gives two responses (an unpaired high surrogate plus
// the next character); those enter the queue together and leave it in order.
// req_ch.ready is high while the queue holds at most one response, so a new
// request is taken while an earlier response still waits to be taken.
// When rsp_ch.ready is low the queue holds its responses and ready drops once
// two are waiting. Reset empties the queue and leaves the decoder idle until
// a start request.
module json_string_unescape_utf8 (
   input  logic  clock,
   input  logic  reset,
   jsu_req_if.sink   req_ch,
   jsu_rsp_if.source rsp_ch
);
   import jsu_pkg::*;

   localparam logic [COUNT_W-1:0] COUNT_CAP =
      (COUNT_LIMIT < 32'hFFFFF) ? COUNT_W'(COUNT_LIMIT) : {COUNT_W{1'b1}};

   mode_type           mode_ff, mode_in;
   logic [CP_W-1:0]    acc_ff, acc_in;
   logic [1:0]         cont_ff, cont_in;
   logic [15:0]        hexacc_ff, hexacc_in;
   logic [2:0]         seen_ff, seen_in;
   logic [15:0]        pend_ff, pend_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CP_W-1:0]    largest_ff, largest_in;

   rsp_entry_type      q_ff [3];
   rsp_entry_type      q_in [3];
   logic [1:0]         cnt_ff, cnt_in;

   logic               accept, pop, flush;
   kind_type           kind;
   logic [7:0]         b;
   logic [CP_W-1:0]    flush_largest;
   act_type            ba, ea;
   hex_type            hd;
   logic [15:0]        hex_new;
   logic [2:0]         seen_new;
   logic               hex_done, is_low, is_high, pend_any;
   logic [CP_W-1:0]    joined_cp;
   logic [1:0]         cl;
   logic [CP_W-1:0]    cont_acc;
   emit_type           e0, e1;
   logic [COUNT_W-1:0] c1, c2;
   logic [CP_W-1:0]    m1, m2;
   rsp_entry_type      r0, r1;
   logic [1:0]         rem;

   assign req_ch.ready = (cnt_ff <= 2'd1);
   assign accept       = req_ch.valid && req_ch.ready;
   assign pop          = rsp_ch.valid && rsp_ch.ready;
   assign kind         = kind_type'(req_ch.kind);
   assign b            = req_ch.data_byte;

   // decode
   assign pend_any      = (pend_ff != 16'd0);
   assign flush         = (kind == KIND_DATA) &&
                          (((mode_ff == MODE_AFTER_HIGH) && (b != CH_BSLASH)) ||
                           ((mode_ff == MODE_AFTER_SLASH) && (b != CH_LOW_U)));
   assign flush_largest = (flush && (CP_W'(pend_ff) > largest_ff)) ? CP_W'(pend_ff)
                                                                  : largest_ff;
   assign ba        = body_act(b, flush_largest);
   assign ea        = esc_act(b);
   assign hd        = hex_digit(b);
   assign hex_new   = {hexacc_ff[11:0], hd.nibble};
   assign seen_new  = seen_ff + 3'd1;
   assign hex_done  = (seen_new == 3'd4);
   assign is_low    = (hex_new >= LOW_SURR_LO) && (hex_new <= LOW_SURR_HI);
   assign is_high   = (hex_new >= HIGH_SURR_LO) && (hex_new <= HIGH_SURR_HI);
   assign joined_cp = 21'h10000 + CP_W'({pend_ff[9:0], hex_new[9:0]});
   assign cl        = cont_ff - 2'd1;

   always_comb begin
      case (cl)
         2'd0:    cont_acc = acc_ff | CP_W'(b[5:0]);
         2'd1:    cont_acc = acc_ff | CP_W'({b[5:0], 6'b0});
         2'd2:    cont_acc = acc_ff | CP_W'({b[5:0], 12'b0});
         default: cont_acc = acc_ff | CP_W'({b[5:0], 18'b0});
      endcase
   end

   // next state
   always_comb begin
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      cont_in   = cont_ff;
      hexacc_in = hexacc_ff;
      seen_in   = seen_ff;
      pend_in   = pend_ff;
      case (kind)
         KIND_START: begin
            mode_in   = MODE_BODY;
            acc_in    = '0;
            cont_in   = '0;
            hexacc_in = '0;
            seen_in   = '0;
            pend_in   = '0;
         end
         KIND_END: begin
            mode_in = MODE_IDLE;
         end
         KIND_DATA: begin
            case (mode_ff)
               MODE_BODY: begin
                  mode_in = ba.mode;
                  if (ba.mode == MODE_CONT) begin
                     acc_in  = ba.acc;
                     cont_in = ba.cont;
                  end
               end
               MODE_CONT: begin
                  cont_in = cl;
                  acc_in  = cont_acc;
                  if (cl == 2'd0) begin
                     mode_in = MODE_BODY;
                  end
               end
               MODE_ESC: begin
                  mode_in = ea.mode;
                  if (ea.mode == MODE_HEX) begin
                     hexacc_in = '0;
                     seen_in   = '0;
                  end
               end
               MODE_HEX: begin
                  if (!hd.valid) begin
                     mode_in = MODE_IDLE;
                  end else begin
                     hexacc_in = hex_new;
                     seen_in   = seen_new;
                     if (hex_done) begin
                        mode_in = MODE_BODY;
                        if (pend_any) begin
                           pend_in = '0;
                        end else if (is_high) begin
                           pend_in = hex_new;
                           mode_in = MODE_AFTER_HIGH;
                        end
                     end
                  end
               end
               MODE_AFTER_HIGH: begin
                  if (b == CH_BSLASH) begin
                     mode_in = MODE_AFTER_SLASH;
                  end else begin
                     pend_in = '0;
                     mode_in = ba.mode;
                     if (ba.mode == MODE_CONT) begin
                        acc_in  = ba.acc;
                        cont_in = ba.cont;
                     end
                  end
               end
               MODE_AFTER_SLASH: begin
                  if (b == CH_LOW_U) begin
                     hexacc_in = '0;
                     seen_in   = '0;
                     mode_in   = MODE_HEX;
                  end else begin
                     pend_in = '0;
                     mode_in = ea.mode;
                     if (ea.mode == MODE_HEX) begin
                        hexacc_in = '0;
                        seen_in   = '0;
                     end
                  end
               end
               default: mode_in = mode_ff;
            endcase
         end
         default: mode_in = mode_ff;
      endcase
   end

   // responses
   always_comb begin
      e0 = '0;
      e1 = '0;
      case (kind)
         KIND_END: begin
            if (mode_ff != MODE_IDLE) begin
               e0.emit   = 1'b1;
               e0.status = ST_ERROR;
            end
         end
         KIND_DATA: begin
            case (mode_ff)
               MODE_BODY: begin
                  e0 = '{ba.emit, ba.status, ba.cp};
               end
               MODE_CONT: begin
                  if (cl == 2'd0) begin
                     e0 = '{1'b1, ST_CHAR, cont_acc};
                  end
               end
               MODE_ESC: begin
                  e0 = '{ea.emit, ea.status, ea.cp};
               end
               MODE_HEX: begin
                  if (!hd.valid) begin
                     e0 = '{1'b1, ST_ERROR, '0};
                  end else if (hex_done) begin
                     if (pend_any && is_low) begin
                        e0 = '{1'b1, ST_CHAR, joined_cp};
                     end else if (pend_any) begin
                        e0 = '{1'b1, ST_CHAR, CP_W'(pend_ff)};
                        e1 = '{1'b1, ST_CHAR, CP_W'(hex_new)};
                     end else if (!is_high) begin
                        e0 = '{1'b1, ST_CHAR, CP_W'(hex_new)};
                     end
                  end
               end
               MODE_AFTER_HIGH: begin
                  if (flush) begin
                     e0 = '{1'b1, ST_CHAR, CP_W'(pend_ff)};
                     e1 = '{ba.emit, ba.status, ba.cp};
                  end
               end
               MODE_AFTER_SLASH: begin
                  if (flush) begin
                     e0 = '{1'b1, ST_CHAR, CP_W'(pend_ff)};
                     e1 = '{ea.emit, ea.status, ea.cp};
                  end
               end
               default: e0 = '0;
            endcase
         end
         default: e0 = '0;
      endcase
   end

   always_comb begin
      c1 = (e0.emit && (e0.status == ST_CHAR) && (count_ff < COUNT_CAP)) ?
           count_ff + COUNT_W'(1) : count_ff;
      m1 = (e0.emit && (e0.status == ST_CHAR) && (e0.cp > largest_ff)) ? e0.cp : largest_ff;
      c2 = (e1.emit && (e1.status == ST_CHAR) && (c1 < COUNT_CAP)) ? c1 + COUNT_W'(1) : c1;
      m2 = (e1.emit && (e1.status == ST_CHAR) && (e1.cp > m1)) ? e1.cp : m1;
      r0 = '{e0.status, (e0.status == ST_CHAR) ? e0.cp : '0, c1, m1, !e1.emit};
      r1 = '{e1.status, (e1.status == ST_CHAR) ? e1.cp : '0, c2, m2, 1'b1};
      if (kind == KIND_START) begin
         count_in   = '0;
         largest_in = '0;
      end else begin
         count_in   = c2;
         largest_in = m2;
      end
   end

   // response queue
   always_comb begin
      logic [1:0] n_push;
      n_push = accept ? (2'(e0.emit) + 2'(e1.emit)) : 2'd0;
      rem    = cnt_ff - 2'(pop);
      cnt_in = rem + n_push;
      q_in[0] = (rem != 2'd0) ? (pop ? q_ff[1] : q_ff[0]) : r0;
      q_in[1] = (rem > 2'd1) ? (pop ? q_ff[2] : q_ff[1]) : ((rem == 2'd1) ? r0 : r1);
      q_in[2] = (rem > 2'd2) ? q_ff[2] : ((rem == 2'd2) ? r0 : ((rem == 2'd1) ? r1 : q_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         acc_ff     <= '0;
         cont_ff    <= '0;
         hexacc_ff  <= '0;
         seen_ff    <= '0;
         pend_ff    <= '0;
         count_ff   <= '0;
         largest_ff <= '0;
         cnt_ff     <= '0;
      end else begin
         if (accept) begin
            mode_ff    <= mode_in;
            acc_ff     <= acc_in;
            cont_ff    <= cont_in;
            hexacc_ff  <= hexacc_in;
            seen_ff    <= seen_in;
            pend_ff    <= pend_in;
            count_ff   <= count_in;
            largest_ff <= largest_in;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      q_ff[2] <= q_in[2];
   end

   assign rsp_ch.valid          = (cnt_ff != 2'd0);
   assign rsp_ch.status         = q_ff[0].status;
   assign rsp_ch.code_point     = q_ff[0].code_point;
   assign rsp_ch.char_count     = q_ff[0].char_count;
   assign rsp_ch.max_code_point = q_ff[0].max_code_point;
   assign rsp_ch.last           = q_ff[0].last;

endmodule

@@ rtl/jsu_checker.sv @@
// Port-level assertions for the JSON string unescape block, with its bind.
module jsu_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [20:0] rsp_code_point,
   input logic [20:0] rsp_max_code_point
);
   import jsu_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_code_point) && $stable(rsp_status))
      else $error("response changed while stalled");

   a_non_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_CHAR) |-> (rsp_code_point == 21'd0))
      else $error("code point set on non-character response");

   a_max_covers: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_CHAR) |-> (rsp_code_point <= rsp_max_code_point))
      else $error("largest code point below current character");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_status         (rsp_ch.status),
   .rsp_code_point     (rsp_ch.code_point),
   .rsp_max_code_point (rsp_ch.max_code_point)
);

@@ test/tb.sv @@
// Testbench for json_string_unescape_utf8: byte stream driver, response checker and predictor.
`timescale 1ns / 1ps

module tb;
   import jsu_pkg::*;

   localparam logic [1:0]  KIND_UNKNOWN = 2'd3;
   localparam logic [19:0] COUNT_CAP =
      (COUNT_LIMIT < 32'hFFFFF) ? COUNT_LIMIT[19:0] : 20'hFFFFF;
   localparam logic [7:0]  ASCII_0  = 8'h30;
   localparam logic [7:0]  ASCII_UA = 8'h41;
   localparam logic [7:0]  ASCII_LA = 8'h61;
   localparam int          PHASE_ITEMS = 200;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
   } byte_req_type;

   logic clock;
   logic reset;

   jsu_req_if req_ch ();
   jsu_rsp_if rsp_ch ();

   json_string_unescape_utf8 dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   byte_req_type  pending_req[$];
   rsp_entry_type expected_rsp[$];

   int send_idle = 25;
   int recv_idle = 84;
   int stim_count = 0;
   int req_count = 0;
   int rsp_count = 0;
   int char_seen = 0;
   int close_seen = 0;
   int error_seen = 0;
   int fail_count = 0;
   logic req_fired = 1'b0;

   // decoder state
   mode_type      dec_mode;
   logic [20:0]   dec_acc;
   logic [1:0]    dec_cont;
   logic [15:0]   dec_hex;
   logic [2:0]    dec_nhex;
   logic [15:0]   dec_high;
   logic [19:0]   dec_count;
   logic [20:0]   dec_largest;
   rsp_entry_type step_out[2];
   int            step_n;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [4:0] hex_nibble(input logic [7:0] b);
      if (b >= ASCII_0 && b <= 8'h39) return {1'b1, 4'(b - ASCII_0)};
      if (b >= ASCII_UA && b <= 8'h46) return {1'b1, 4'(b - ASCII_UA + 8'd10)};
      if (b >= ASCII_LA && b <= 8'h66) return {1'b1, 4'(b - ASCII_LA + 8'd10)};
      return 5'd0;
   endfunction

   task automatic clear_string_state();
      dec_mode    = MODE_IDLE;
      dec_acc     = '0;
      dec_cont    = '0;
      dec_hex     = '0;
      dec_nhex    = '0;
      dec_high    = '0;
      dec_count   = '0;
      dec_largest = '0;
   endtask

   task automatic put_result(input status_type st, input logic [20:0] cp);
      logic [20:0] v;
      v = cp;
      if (st == ST_CHAR) begin
         if (dec_count < COUNT_CAP) dec_count = dec_count + 20'd1;
         if (v > dec_largest) dec_largest = v;
      end else begin
         v = '0;
      end
      if (step_n < 2) begin
         step_out[step_n] = '{status: st, code_point: v, char_count: dec_count,
                              max_code_point: dec_largest, last: 1'b0};
         step_n++;
      end
   endtask

   task automatic abort_string();
      put_result(ST_ERROR, '0);
      dec_mode = MODE_IDLE;
   endtask

   task automatic flush_high();
      put_result(ST_CHAR, 21'(dec_high));
      dec_high = '0;
   endtask

   task automatic body_byte(input logic [7:0] b);
      if (b == CH_BSLASH) begin
         dec_mode = MODE_ESC;
      end else if (b == CH_QUOTE) begin
         put_result((dec_largest > UNICODE_LAST) ? ST_ERROR : ST_CLOSE, '0);
         dec_mode = MODE_IDLE;
      end else if ((b & 8'h80) == 8'h00) begin
         put_result(ST_CHAR, 21'(b));
      end else if ((b & 8'hE0) == 8'hC0) begin
         dec_acc  = 21'(b & 8'h1F) << 6;
         dec_cont = 2'd1;
         dec_mode = MODE_CONT;
      end else if ((b & 8'hF0) == 8'hE0) begin
         dec_acc  = 21'(b & 8'h0F) << 12;
         dec_cont = 2'd2;
         dec_mode = MODE_CONT;
      end else if ((b & 8'hF8) == 8'hF0) begin
         dec_acc  = 21'(b & 8'h07) << 18;
         dec_cont = 2'd3;
         dec_mode = MODE_CONT;
      end else begin
         abort_string();
      end
   endtask

   task automatic cont_byte(input logic [7:0] b);
      dec_cont = dec_cont - 2'd1;
      dec_acc  = dec_acc | (21'(b & 8'h3F) << (6 * dec_cont));
      if (dec_cont == 2'd0) begin
         put_result(ST_CHAR, dec_acc);
         dec_mode = MODE_BODY;
      end
   endtask

   task automatic esc_byte(input logic [7:0] b);
      logic [7:0] v;
      v = 8'h00;
      case (b)
         CH_QUOTE:  v = 8'h22;
         CH_BSLASH: v = 8'h5C;
         CH_LOW_B:  v = 8'h08;
         CH_LOW_F:  v = 8'h0C;
         CH_LOW_N:  v = 8'h0A;
         CH_LOW_R:  v = 8'h0D;
         CH_LOW_T:  v = 8'h09;
         default:   v = 8'h00;
      endcase
      if (v != 8'h00) begin
         put_result(ST_CHAR, 21'(v));
         dec_mode = MODE_BODY;
      end else if (b == CH_LOW_U) begin
         dec_hex  = '0;
         dec_nhex = '0;
         dec_mode = MODE_HEX;
      end else begin
         abort_string();
      end
   endtask

   task automatic hex_byte(input logic [7:0] b);
      logic [4:0]  d;
      logic [15:0] v;
      d = hex_nibble(b);
      if (!d[4]) begin
         abort_string();
         return;
      end
      dec_hex  = {dec_hex[11:0], d[3:0]};
      dec_nhex = dec_nhex + 3'd1;
      if (dec_nhex < 3'd4) return;
      v = dec_hex;
      dec_mode = MODE_BODY;
      if (dec_high != 16'h0000) begin
         if (v >= LOW_SURR_LO && v <= LOW_SURR_HI) begin
            put_result(ST_CHAR, 21'h10000 + (21'(dec_high - HIGH_SURR_LO) << 10)
                                + 21'(v - LOW_SURR_LO));
            dec_high = '0;
         end else begin
            flush_high();
            put_result(ST_CHAR, 21'(v));
         end
      end else if (v >= HIGH_SURR_LO && v <= HIGH_SURR_HI) begin
         dec_high = v;
         dec_mode = MODE_AFTER_HIGH;
      end else begin
         put_result(ST_CHAR, 21'(v));
      end
   endtask

   task automatic predict_request(input logic [1:0] kind, input logic [7:0] b);
      step_n = 0;
      if (kind == KIND_START) begin
         clear_string_state();
         dec_mode = MODE_BODY;
      end else if (kind == KIND_END) begin
         if (dec_mode != MODE_IDLE) abort_string();
      end else if (kind == KIND_DATA) begin
         case (dec_mode)
            MODE_BODY: body_byte(b);
            MODE_CONT: cont_byte(b);
            MODE_ESC:  esc_byte(b);
            MODE_HEX:  hex_byte(b);
            MODE_AFTER_HIGH: begin
               if (b == CH_BSLASH) begin
                  dec_mode = MODE_AFTER_SLASH;
               end else begin
                  flush_high();
                  dec_mode = MODE_BODY;
                  body_byte(b);
               end
            end
            MODE_AFTER_SLASH: begin
               if (b == CH_LOW_U) begin
                  dec_hex  = '0;
                  dec_nhex = '0;
                  dec_mode = MODE_HEX;
               end else begin
                  flush_high();
                  dec_mode = MODE_ESC;
                  esc_byte(b);
               end
            end
            default: ;
         endcase
      end
      if (step_n > 0) step_out[step_n-1].last = 1'b1;
      for (int i = 0; i < step_n; i++) expected_rsp.push_back(step_out[i]);
   endtask

   // stimulus builders
   task automatic queue_req(input logic [1:0] kind, input logic [7:0] b);
      pending_req.push_back('{kind: kind, data_byte: b});
      stim_count++;
   endtask

   task automatic queue_byte(input logic [7:0] b);
      queue_req(KIND_DATA, b);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return ASCII_0 + 8'(n);
      return ($urandom_range(0, 1) ? ASCII_UA : ASCII_LA) + 8'(n - 4'd10);
   endfunction

   task automatic queue_unicode(input logic [15:0] v);
      queue_byte(CH_BSLASH);
      queue_byte(CH_LOW_U);
      queue_byte(hex_char(v[15:12]));
      queue_byte(hex_char(v[11:8]));
      queue_byte(hex_char(v[7:4]));
      queue_byte(hex_char(v[3:0]));
   endtask

   function automatic logic [7:0] cont_char();
      if ($urandom_range(0, 4) == 0) return 8'($urandom);
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   function automatic logic [7:0] simple_escape();
      case ($urandom_range(0, 6))
         0:       return CH_QUOTE;
         1:       return CH_BSLASH;
         2:       return CH_LOW_B;
         3:       return CH_LOW_F;
         4:       return CH_LOW_N;
         5:       return CH_LOW_R;
         default: return CH_LOW_T;
      endcase
   endfunction

   function automatic logic [15:0] high_surrogate();
      return HIGH_SURR_LO + 16'($urandom_range(0, 1023));
   endfunction

   function automatic logic [15:0] low_surrogate();
      return LOW_SURR_LO + 16'($urandom_range(0, 1023));
   endfunction

   task automatic queue_random_char();
      logic [7:0]  b;
      logic [15:0] v;
      case ($urandom_range(0, 15))
         5: begin
            queue_byte(8'hC0 | 8'($urandom_range(0, 31)));
            queue_byte(cont_char());
         end
         6: begin
            queue_byte(8'hE0 | 8'($urandom_range(0, 15)));
            repeat (2) queue_byte(cont_char());
         end
         7: begin
            queue_byte(8'hF0 | 8'($urandom_range(0, 7)));
            repeat (3) queue_byte(cont_char());
         end
         8: begin
            queue_byte(CH_BSLASH);
            queue_byte(simple_escape());
         end
         9: queue_unicode(16'($urandom));
         10, 11: begin
            queue_unicode(high_surrogate());
            queue_unicode(low_surrogate());
         end
         12: queue_unicode(high_surrogate());
         13: begin
            queue_unicode(high_surrogate());
            v = 16'($urandom);
            while (v >= LOW_SURR_LO && v <= LOW_SURR_HI) v = 16'($urandom);
            queue_unicode(v);
         end
         14: begin
            queue_unicode(high_surrogate());
            queue_byte(CH_BSLASH);
            queue_byte(simple_escape());
         end
         15: queue_unicode(low_surrogate());
         default: begin
            b = 8'($urandom_range(0, 127));
            if (b == CH_QUOTE || b == CH_BSLASH) b = ASCII_LA;
            queue_byte(b);
         end
      endcase
   endtask

   task automatic queue_string();
      logic [7:0] b;
      logic [4:0] d;
      int         n;
      queue_req(KIND_START, 8'($urandom));
      n = $urandom_range(0, 10);
      repeat (n) queue_random_char();
      case ($urandom_range(0, 19))
         14: queue_req(KIND_END, 8'($urandom));
         15: queue_byte($urandom_range(0, 1) ? 8'h80 | 8'($urandom_range(0, 63))
                                              : 8'hF8 | 8'($urandom_range(0, 7)));
         16: begin
            queue_byte(CH_BSLASH);
            b = 8'($urandom);
            while (b == CH_LOW_U || b == CH_QUOTE || b == CH_BSLASH || b == CH_LOW_B ||
                   b == CH_LOW_F || b == CH_LOW_N || b == CH_LOW_R || b == CH_LOW_T)
               b = 8'($urandom);
            queue_byte(b);
         end
         17: begin
            queue_byte(CH_BSLASH);
            queue_byte(CH_LOW_U);
            repeat ($urandom_range(0, 3)) queue_byte(hex_char(4'($urandom)));
            b = 8'($urandom);
            d = hex_nibble(b);
            while (d[4]) begin
               b = 8'($urandom);
               d = hex_nibble(b);
            end
            queue_byte(b);
         end
         18: ;
         19: begin
            queue_unicode(high_surrogate());
            queue_req(KIND_END, 8'($urandom));
         end
         default: queue_byte(CH_QUOTE);
      endcase
      if ($urandom_range(0, 5) == 0) begin
         // trailing noise of data, end or unknown kind, not counted
         repeat ($urandom_range(1, 3))
            pending_req.push_back('{kind: 2'($urandom_range(1, 3)), data_byte: 8'($urandom)});
      end
   endtask

   task automatic wait_drained();
      while (pending_req.size() != 0 || req_ch.valid) @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input rsp_entry_type want, input rsp_entry_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("tb: mismatch expected st %0d cp %h cnt %0d max %h last %b",
                  want.status, want.code_point, want.char_count, want.max_code_point,
                  want.last);
         $display("tb:          got      st %0d cp %h cnt %0d max %h last %b",
                  got.status, got.code_point, got.char_count, got.max_code_point,
                  got.last);
      end
   endtask

   // driver
   always @(negedge clock) begin : drive_req
      byte_req_type item;
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.kind      <= KIND_START;
         req_ch.data_byte <= 8'h00;
         rsp_ch.ready     <= 1'b0;
      end else begin
         if (!req_ch.valid || req_fired) begin
            if (pending_req.size() > 0 && $urandom_range(99) >= send_idle) begin
               item = pending_req.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.kind      <= item.kind;
               req_ch.data_byte <= item.data_byte;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // monitor and checker
   always @(posedge clock) begin : watch_rsp
      rsp_entry_type got;
      rsp_entry_type want;
      req_fired = !reset && req_ch.valid && req_ch.ready;
      if (req_fired) begin
         predict_request(req_ch.kind, req_ch.data_byte);
         req_count++;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{status: status_type'(rsp_ch.status), code_point: rsp_ch.code_point,
                 char_count: rsp_ch.char_count, max_code_point: rsp_ch.max_code_point,
                 last: rsp_ch.last};
         rsp_count++;
         if (got.status == ST_CHAR) char_seen++;
         else if (got.status == ST_CLOSE) close_seen++;
         else error_seen++;
         if (expected_rsp.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("tb: response with none expected: st %0d cp %h cnt %0d max %h last %b",
                        got.status, got.code_point, got.char_count, got.max_code_point,
                        got.last);
         end else begin
            want = expected_rsp.pop_front();
            if (got.status !== want.status || got.code_point !== want.code_point ||
                got.char_count !== want.char_count ||
                got.max_code_point !== want.max_code_point || got.last !== want.last)
               report_mismatch(want, got);
         end
      end
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

   initial begin : main
      reset = 1'b1;
      clear_string_state();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: ignored while idle, extremes, too large at close, bad lead,
      // unpaired high surrogate before a plain byte, bad escape
      queue_req(KIND_DATA, ASCII_UA);
      queue_req(KIND_END, 8'hFF);
      queue_req(KIND_UNKNOWN, 8'h00);
      queue_req(KIND_START, 8'h00);
      queue_byte(8'h00);
      queue_byte(8'h7F);
      queue_byte(8'hF7);
      repeat (3) queue_byte(8'hBF);
      queue_byte(CH_BSLASH);
      queue_byte(CH_LOW_T);
      queue_byte(CH_QUOTE);
      queue_req(KIND_START, 8'hFF);
      queue_byte(8'hFF);
      queue_req(KIND_START, 8'h00);
      queue_unicode(HIGH_SURR_LO);
      queue_byte(ASCII_UA);
      queue_req(KIND_START, 8'h00);
      queue_byte(CH_BSLASH);
      queue_byte(8'h78);
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 25 : (phase == 1) ? 84 : 0;
         recv_idle = (phase == 0) ? 84 : (phase == 1) ? 25 : 0;
         stim_count = 0;
         while (stim_count < PHASE_ITEMS) queue_string();
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (expected_rsp.size() != 0) fail_count++;
      $display("tb: %0d requests, %0d responses checked (%0d chars, %0d closes, %0d errors)",
               req_count, rsp_count, char_seen, close_seen, error_seen);
      $display("tb: idle mixes sender/receiver 25/84, 84/25 and 0/0, %0d mismatches",
               fail_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
